// ===== rtl/cdo_pkg.sv =====
// Shared types and constants for the current disturbance observer.
// No dependencies; used by cdo_axis, current_disturbance_observer and the testbench.
package cdo_pkg;

    localparam int SIG_W      = 16;
    localparam int GAIN_W     = 18;
    localparam int FRAC_SHIFT = 16;
    localparam int SIG_MAX    = 32767;
    localparam int SIG_MIN    = -32768;

    localparam int ACC_W  = GAIN_W + SIG_W + 3;     // sum of three products
    localparam int PRD_W  = GAIN_W + SIG_W + 1;     // gain times 17-bit value
    localparam int IEST_W = ACC_W - FRAC_SHIFT;     // rounded current update
    localparam int DSTP_W = PRD_W - FRAC_SHIFT;     // rounded disturbance step
    localparam int DSUM_W = DSTP_W + 1;             // disturbance before clip

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic signed [SIG_W-1:0]  sig_t;
    typedef logic signed [GAIN_W-1:0] gain_t;

    typedef enum logic [1:0] {
        REG_GAIN_A  = 2'd0,
        REG_GAIN_B  = 2'd1,
        REG_GAIN_CI = 2'd2,
        REG_GAIN_DI = 2'd3
    } reg_idx_t;

    typedef struct packed {
        sig_t meas_current_alpha;
        sig_t meas_current_beta;
        sig_t applied_volt_alpha;
        sig_t applied_volt_beta;
    } in_t;

    typedef struct packed {
        sig_t est_current_alpha;
        sig_t est_current_beta;
        sig_t est_disturb_alpha;
        sig_t est_disturb_beta;
        logic saturated;
    } out_t;

    typedef struct packed {
        gain_t a;
        gain_t b;
        gain_t current_inject;
        gain_t disturb_inject;
    } gains_t;

    typedef struct packed {
        sig_t est_current;
        sig_t est_disturb;
        logic saturated;
    } axis_res_t;

endpackage

// ===== rtl/cdo_axis.sv =====
// One-axis observer update: error, four products, rounding and clipping.
// Depends on cdo_pkg.
module cdo_axis (
    input  cdo_pkg::gains_t    gains,
    input  cdo_pkg::sig_t      meas,
    input  cdo_pkg::sig_t      volt,
    input  cdo_pkg::sig_t      i_hat,
    input  cdo_pkg::sig_t      d_hat,
    output cdo_pkg::axis_res_t res
);
    import cdo_pkg::*;

    localparam logic [ACC_W-1:0] ROUND_ACC = ACC_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [PRD_W-1:0] ROUND_PRD = PRD_W'(1) << (FRAC_SHIFT - 1);

    logic signed [SIG_W:0]          err;
    logic signed [SIG_W:0]          vsum;
    logic signed [GAIN_W+SIG_W-1:0] prod_a;
    logic signed [PRD_W-1:0]        prod_b;
    logic signed [PRD_W-1:0]        prod_i;
    logic signed [PRD_W-1:0]        prod_d;
    logic signed [ACC_W-1:0]        acc;
    logic        [ACC_W-1:0]        acc_rnd;
    logic        [PRD_W-1:0]        prod_d_rnd;
    logic signed [IEST_W-1:0]       i_full;
    logic signed [DSTP_W-1:0]       d_step;
    logic signed [DSUM_W-1:0]       d_full;
    logic                           i_hi, i_lo, d_hi, d_lo;

    always_comb begin
        err    = {meas[SIG_W-1], meas} - {i_hat[SIG_W-1], i_hat};
        vsum   = {volt[SIG_W-1], volt} + {d_hat[SIG_W-1], d_hat};
        prod_a = gains.a * i_hat;
        prod_b = gains.b * vsum;
        prod_i = gains.current_inject * err;
        prod_d = gains.disturb_inject * err;

        // Exact sum with 28 fraction bits, then one round-half-up to 12.
        acc     = ACC_W'(prod_a) + ACC_W'(prod_b) + ACC_W'(prod_i);
        acc_rnd = acc + ROUND_ACC;
        i_full  = acc_rnd[ACC_W-1:FRAC_SHIFT];

        prod_d_rnd = prod_d + ROUND_PRD;
        d_step     = prod_d_rnd[PRD_W-1:FRAC_SHIFT];
        d_full     = DSUM_W'(d_hat) + DSUM_W'(d_step);

        i_hi = i_full > IEST_W'(SIG_MAX);
        i_lo = i_full < IEST_W'(SIG_MIN);
        d_hi = d_full > DSUM_W'(SIG_MAX);
        d_lo = d_full < DSUM_W'(SIG_MIN);

        priority if (i_hi) begin
            res.est_current = sig_t'(SIG_MAX);
        end else if (i_lo) begin
            res.est_current = sig_t'(SIG_MIN);
        end else begin
            res.est_current = i_full[SIG_W-1:0];
        end

        priority if (d_hi) begin
            res.est_disturb = sig_t'(SIG_MAX);
        end else if (d_lo) begin
            res.est_disturb = sig_t'(SIG_MIN);
        end else begin
            res.est_disturb = d_full[SIG_W-1:0];
        end

        res.saturated = i_hi | i_lo | d_hi | d_lo;
    end

endmodule

// ===== rtl/current_disturbance_observer.sv =====
// Top level of the two-axis current and disturbance observer.
// Depends on cdo_pkg and cdo_axis.
//
// Usage: each request on the s_ channel carries one sample of measured
// alpha/beta currents and applied alpha/beta voltages, all signed Q3.12.
// Each sample produces exactly one request on the m_ channel with the
// updated current and disturbance estimates and a flag that is set when
// any of the four estimates was clipped to the 16-bit range.
// An accepted sample waits in the input register until its update, computed
// combinationally, moves into the result register. One sample can be
// accepted every cycle while m_ready stays high: the input register refills
// in the same cycle its contents move into the result register. The
// observer state lives in the result register itself, so the update for a
// sample always sees the estimates left by the previous one. When the
// receiver holds m_ready low, the result stays in place, one more sample
// waits in the input register, and then s_ready drops. Synchronous
// active-low reset clears both valid flags, all four estimates and the four
// gains. Gains are written over the APB port (byte address 4*i); the user
// must do so only while no sample is in flight; the block does not enforce it.
module current_disturbance_observer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cdo_pkg::in_t                  s_data,
    // result requests
    output logic                          m_valid,
    input  logic                          m_ready,
    output cdo_pkg::out_t                 m_data,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cdo_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cdo_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cdo_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import cdo_pkg::*;

    gains_t    gains_reg;
    in_t       in_reg;
    logic      in_valid_reg;
    logic      out_valid_reg;
    sig_t      ia_reg, ib_reg, da_reg, db_reg;
    logic      sat_reg;

    logic      advance;
    logic      cfg_write;
    reg_idx_t  cfg_idx;
    gain_t     rd_gain;
    axis_res_t res_a, res_b;

    // The result register takes the pending sample's update when it is empty or being taken.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    assign m_data.est_current_alpha = ia_reg;
    assign m_data.est_current_beta  = ib_reg;
    assign m_data.est_disturb_alpha = da_reg;
    assign m_data.est_disturb_beta  = db_reg;
    assign m_data.saturated         = sat_reg;

    always_comb begin
        unique case (cfg_idx)
            REG_GAIN_A:  rd_gain = gains_reg.a;
            REG_GAIN_B:  rd_gain = gains_reg.b;
            REG_GAIN_CI: rd_gain = gains_reg.current_inject;
            REG_GAIN_DI: rd_gain = gains_reg.disturb_inject;
            default:     rd_gain = '0;
        endcase
        prdata = APB_DATA_W'(rd_gain);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_GAIN_A:  gains_reg.a              <= pwdata[GAIN_W-1:0];
                REG_GAIN_B:  gains_reg.b              <= pwdata[GAIN_W-1:0];
                REG_GAIN_CI: gains_reg.current_inject <= pwdata[GAIN_W-1:0];
                REG_GAIN_DI: gains_reg.disturb_inject <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    cdo_axis u_axis_alpha (
        .gains (gains_reg),
        .meas  (in_reg.meas_current_alpha),
        .volt  (in_reg.applied_volt_alpha),
        .i_hat (ia_reg),
        .d_hat (da_reg),
        .res   (res_a)
    );

    cdo_axis u_axis_beta (
        .gains (gains_reg),
        .meas  (in_reg.meas_current_beta),
        .volt  (in_reg.applied_volt_beta),
        .i_hat (ib_reg),
        .d_hat (db_reg),
        .res   (res_b)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Result register, which is also the observer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            ia_reg        <= '0;
            ib_reg        <= '0;
            da_reg        <= '0;
            db_reg        <= '0;
            sat_reg       <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                ia_reg        <= res_a.est_current;
                ib_reg        <= res_b.est_current;
                da_reg        <= res_a.est_disturb;
                db_reg        <= res_b.est_disturb;
                sat_reg       <= res_a.saturated | res_b.saturated;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The state may only change when a sample moves into the result register.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(ia_reg) && $stable(ib_reg) &&
                      $stable(da_reg) && $stable(db_reg)))
        else $error("observer state changed without a sample");

    // Every processed sample is offered on the result channel.
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed sample not offered");

    // An accepted sample is held in the input register.
    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted sample lost");

    // A pending sample is never overwritten while the result is stalled.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input register overwritten while stalled");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the two-axis current and disturbance observer.
// Depends on cdo_pkg and current_disturbance_observer from the RTL folder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cdo_pkg::*;

    // Quiet cycles (no request accepted anywhere) before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Length of the deliberate receiver hold-off in the back-pressure test.
    localparam int LONG_HOLD   = 64;
    // Random samples per gain setting in the random phases.
    localparam int PHASE_ITEMS = 150;

    logic aclk;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    current_disturbance_observer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Observer model. The gains mirror the registers as last written, and
    // the four estimates mirror the state the block carries from sample to
    // sample. Everything is held as 64-bit signed so no product overflows.
    // ------------------------------------------------------------------
    longint gain_a_q  = 0;
    longint gain_b_q  = 0;
    longint gain_ci_q = 0;
    longint gain_di_q = 0;

    longint est_i_alpha = 0;
    longint est_i_beta  = 0;
    longint est_d_alpha = 0;
    longint est_d_beta  = 0;

    out_t pending_estimates[$];

    int samples_sent    = 0;
    int results_checked = 0;
    int clipped_results = 0;
    int gain_settings   = 0;
    int error_count     = 0;

    // Idle controls shared by the sender and the receiver.
    int send_gap_max   = 8;
    int recv_gap_max   = 8;
    int long_hold_req  = 0;

    function automatic longint clip16(input longint x);
        if (x > SIG_MAX) return SIG_MAX;
        if (x < SIG_MIN) return SIG_MIN;
        return x;
    endfunction

    // One axis of the update. Both the current and the disturbance update use
    // the estimates from before this sample. The sums are rounded half up by
    // adding half an output LSB and flooring, which an arithmetic shift does.
    task automatic advance_axis(input longint meas, input longint volt,
                                inout longint i_hat, inout longint d_hat,
                                inout bit clipped);
        longint err;
        longint vsum;
        longint acc;
        longint i_next;
        longint d_next;
        err    = meas - i_hat;
        vsum   = volt + d_hat;
        acc    = gain_a_q * i_hat + gain_b_q * vsum + gain_ci_q * err;
        i_next = (acc + 64'sd32768) >>> FRAC_SHIFT;
        d_next = d_hat + ((gain_di_q * err + 64'sd32768) >>> FRAC_SHIFT);
        if (clip16(i_next) != i_next || clip16(d_next) != d_next) clipped = 1'b1;
        i_hat = clip16(i_next);
        d_hat = clip16(d_next);
    endtask

    task automatic predict_estimates(input in_t smp, output out_t res);
        bit clipped;
        clipped = 1'b0;
        advance_axis(longint'(smp.meas_current_alpha), longint'(smp.applied_volt_alpha),
                     est_i_alpha, est_d_alpha, clipped);
        advance_axis(longint'(smp.meas_current_beta), longint'(smp.applied_volt_beta),
                     est_i_beta, est_d_beta, clipped);
        res.est_current_alpha = sig_t'(est_i_alpha);
        res.est_current_beta  = sig_t'(est_i_beta);
        res.est_disturb_alpha = sig_t'(est_d_alpha);
        res.est_disturb_beta  = sig_t'(est_d_beta);
        res.saturated         = clipped;
    endtask

    task automatic compare_field(input string name, input logic signed [SIG_W-1:0] want,
                                 input logic signed [SIG_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        if (pending_estimates.size() == 0) begin
            $error("result request arrived with no sample outstanding");
            error_count++;
            return;
        end
        want = pending_estimates.pop_front();
        compare_field("est_current_alpha", want.est_current_alpha, got.est_current_alpha);
        compare_field("est_current_beta",  want.est_current_beta,  got.est_current_beta);
        compare_field("est_disturb_alpha", want.est_disturb_alpha, got.est_disturb_alpha);
        compare_field("est_disturb_beta",  want.est_disturb_beta,  got.est_disturb_beta);
        compare_field("saturated", {{(SIG_W-1){1'b0}}, want.saturated},
                      {{(SIG_W-1){1'b0}}, got.saturated});
        results_checked++;
        if (want.saturated) clipped_results++;
    endtask

    // Monitor. Results are checked before the sample of the same edge is
    // predicted, so a result can never be matched against its own sample.
    always @(posedge aclk) begin
        if (aresetn) begin
            out_t res;
            if (m_valid === 1'b1 && m_ready) check_result(m_data);
            if (s_valid && s_ready === 1'b1) begin
                predict_estimates(s_data, res);
                pending_estimates.push_back(res);
            end
        end
    end

    // Receiver. For every result it holds m_ready low for a random number of
    // cycles, then waits with m_ready high until the result is taken. A test
    // can ask for one long hold-off, which is counted here.
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold_req > 0) begin
                stall = long_hold_req;
                long_hold_req = 0;
            end else begin
                stall = (recv_gap_max > 0) ? $urandom_range(0, recv_gap_max) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
        end
    end

    // Watchdog: any accepted request or register write resets the count.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (psel && penable && pwrite && pready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no request accepted for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared drivers. Every task starts and ends right after a rising edge.
    // ------------------------------------------------------------------

    // Offer one sample after a random gap and hold it until it is accepted.
    // Valid is only lowered when a gap follows, so back-to-back requests keep
    // it high without a second assignment in the same step.
    task automatic send_sample(input in_t smp);
        int gap;
        gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        samples_sent++;
    endtask

    task automatic send_fields(input longint ma, input longint mb,
                               input longint va, input longint vb);
        in_t smp;
        smp.meas_current_alpha = sig_t'(ma);
        smp.meas_current_beta  = sig_t'(mb);
        smp.applied_volt_alpha = sig_t'(va);
        smp.applied_volt_beta  = sig_t'(vb);
        send_sample(smp);
    endtask

    // Stop offering samples and wait until every sample sent has been
    // answered. The sender's own count is used, since the monitor may not
    // yet have recorded a sample accepted at this very edge.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (results_checked < samples_sent) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready. Bits above the
    // 18-bit gain carry junk, which the block must ignore. The bus is left
    // selected so the next write can follow directly; set_gains releases it.
    task automatic write_gain(input reg_idx_t idx, input longint val);
        logic [APB_DATA_W-1:0] word;
        word        = $urandom;
        word[17:0]  = val[17:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (pready !== 1'b1) @(posedge aclk);
        case (idx)
            REG_GAIN_A:  gain_a_q  = longint'(gain_t'(val));
            REG_GAIN_B:  gain_b_q  = longint'(gain_t'(val));
            REG_GAIN_CI: gain_ci_q = longint'(gain_t'(val));
            REG_GAIN_DI: gain_di_q = longint'(gain_t'(val));
            default: ;
        endcase
    endtask

    task automatic set_gains(input longint a, input longint b,
                             input longint ci, input longint di);
        write_gain(REG_GAIN_A, a);
        write_gain(REG_GAIN_B, b);
        write_gain(REG_GAIN_CI, ci);
        write_gain(REG_GAIN_DI, di);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        gain_settings++;
    endtask

    // Mostly full-range values, with extremes and small realistic values mixed in.
    function automatic sig_t rand_signal();
        case ($urandom_range(0, 9))
            0: return sig_t'(SIG_MAX);
            1: return sig_t'(SIG_MIN);
            2, 3, 4: return sig_t'(int'($urandom_range(0, 8191)) - 4096);
            default: return sig_t'($urandom);
        endcase
    endfunction

    function automatic longint rand_gain();
        return longint'(gain_t'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With the gains still at their reset value, every estimate stays zero.
    task automatic test_reset_gains();
        send_fields(SIG_MAX, SIG_MIN, SIG_MAX, SIG_MIN);
        send_fields(SIG_MIN, SIG_MAX, SIG_MIN, SIG_MAX);
        wait_results_drained();
    endtask

    // Gains of one half on the error put products exactly on a half LSB,
    // which must round up for both positive and negative errors.
    task automatic test_rounding();
        set_gains(0, 0, 32768, 32768);
        send_fields(1, -1, 0, 0);
        send_fields(-1, 1, 5, -5);
        send_fields(-3, 3, 0, 0);
        send_fields(3, -3, -7, 7);
        wait_results_drained();
    endtask

    // Largest and smallest gains with full-scale inputs drive every estimate
    // into both clip limits.
    task automatic test_saturation();
        set_gains(131071, 131071, 131071, 131071);
        send_fields(SIG_MAX, SIG_MAX, SIG_MAX, SIG_MAX);
        send_fields(SIG_MAX, SIG_MAX, SIG_MAX, SIG_MAX);
        send_fields(SIG_MIN, SIG_MIN, SIG_MIN, SIG_MIN);
        send_fields(SIG_MIN, SIG_MIN, SIG_MIN, SIG_MIN);
        wait_results_drained();
        set_gains(-131072, -131072, -131072, -131072);
        send_fields(SIG_MAX, SIG_MIN, SIG_MAX, SIG_MIN);
        send_fields(SIG_MAX, SIG_MIN, SIG_MAX, SIG_MIN);
        send_fields(SIG_MIN, SIG_MAX, SIG_MIN, SIG_MAX);
        send_fields(SIG_MIN, SIG_MAX, SIG_MIN, SIG_MAX);
        wait_results_drained();
    endtask

    // Field extremes and values around zero with a unity pole.
    task automatic test_field_extremes();
        set_gains(65536, 16384, 8192, 4096);
        send_fields(0, 0, 0, 0);
        send_fields(-1, 1, -1, 1);
        send_fields(SIG_MAX, 0, SIG_MIN, -1);
        send_fields(SIG_MIN, -1, SIG_MAX, 0);
        send_fields(0, SIG_MAX, 1, SIG_MIN);
        send_fields(1, SIG_MIN, 0, SIG_MAX);
        wait_results_drained();
    endtask

    // The receiver holds off for a long stretch while samples keep coming
    // back to back, so the block fills and must stall its input.
    task automatic test_backpressure();
        set_gains(58982, 6554, 19661, 3277);
        send_gap_max  = 0;
        long_hold_req = LONG_HOLD;
        repeat (24) send_sample('{rand_signal(), rand_signal(), rand_signal(),
                                  rand_signal()});
        wait_results_drained();
        send_gap_max = 8;
    endtask

    // The sender stops until every result is back, then resumes with the
    // same gains; the carried state must continue where it left off.
    task automatic test_pause_and_resume();
        repeat (12) send_sample('{rand_signal(), rand_signal(), rand_signal(),
                                  rand_signal()});
        wait_results_drained();
        repeat (12) send_sample('{rand_signal(), rand_signal(), rand_signal(),
                                  rand_signal()});
        wait_results_drained();
    endtask

    // Random samples over a range of gain settings. Every third setting runs
    // with no idling on either side.
    task automatic test_random_settings();
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: set_gains(58982, 6554, 19661, 3277);     // well-behaved observer
                1: set_gains(131071, -131072, 0, 131071);
                2: set_gains(-131072, 131071, -131072, -131072);
                default: set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
            endcase
            send_gap_max = (k % 3 == 2) ? 0 : 8;
            recv_gap_max = (k % 3 == 2) ? 0 : 8;
            repeat (PHASE_ITEMS) send_sample('{rand_signal(), rand_signal(),
                                               rand_signal(), rand_signal()});
            wait_results_drained();
        end
        send_gap_max = 8;
        recv_gap_max = 8;
    endtask

    initial begin : main_sequence
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_gains();
        test_rounding();
        test_saturation();
        test_field_extremes();
        test_backpressure();
        test_pause_and_resume();
        test_random_settings();

        wait_results_drained();
        if (pending_estimates.size() != 0) begin
            $error("%0d expected results never arrived", pending_estimates.size());
            error_count++;
        end

        $display("Checked %0d results from %0d samples over %0d gain settings, %0d clipped.",
                 results_checked, samples_sent, gain_settings, clipped_results);
        $display("Included a %0d-cycle receiver hold-off and pauses until fully drained.",
                 LONG_HOLD);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
